// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the UTF-8 validator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define U8VC_ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("u8vc assertion failed");

// Check that a trigger is followed by a condition in the next cycle.
`define U8VC_ASSERT_NEXT(lbl, clk, rst, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("u8vc assertion failed");

`endif

// ===== hw/rtl/u8vc_pkg.sv =====
// Types and constants of the UTF-8 validator and counter.
// No dependencies; used by every module of the block.
`default_nettype none

package u8vc_pkg;

  // Largest buffer length that counters track; counters stop at the cap
  localparam longint unsigned MAX_BYTES = 64'd65535;
  localparam logic [15:0] COUNT_CAP =
    (MAX_BYTES < 64'd65535) ? 16'(MAX_BYTES) : 16'hFFFF;

  // Lead byte patterns
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;
  localparam logic [7:0] ASCII_TOP  = 8'h80;

  // Code point limits
  localparam logic [20:0] MIN_2BYTE  = 21'h00080;
  localparam logic [20:0] MIN_3BYTE  = 21'h00800;
  localparam logic [20:0] SURR_LOW   = 21'h0D800;
  localparam logic [20:0] SURR_HIGH  = 21'h0DFFF;
  localparam logic [20:0] MIN_4BYTE  = 21'h10000;
  localparam logic [20:0] MAX_CODEPT = 21'h10FFFF;

  // Continuation counts of an open sequence
  localparam logic [1:0] CONT_ONE   = 2'd1;
  localparam logic [1:0] CONT_TWO   = 2'd2;
  localparam logic [1:0] CONT_THREE = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic        valid_flag;
    logic [15:0] valid_bytes;
    logic [15:0] char_count;
    logic [15:0] utf16_units;
  } result_t;

  typedef struct packed {
    logic       discarding;
    logic [1:0] bytes_pending;
    logic [1:0] sequence_length;
  } step_status_t;

  // Increment that stops at the counter cap
  function automatic logic [15:0] sat_inc(input logic [15:0] x);
    return (x < COUNT_CAP) ? x + 16'd1 : COUNT_CAP;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/u8vc_byte_if.sv =====
// Byte channel of the UTF-8 validator: valid/ready plus one byte item.
// No dependencies.
`default_nettype none

interface u8vc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/u8vc_result_if.sv =====
// Result channel of the UTF-8 validator: valid/ready plus one result item.
// No dependencies.
`default_nettype none

interface u8vc_result_if;
  logic        valid;
  logic        ready;
  logic        valid_flag;
  logic [15:0] valid_bytes;
  logic [15:0] char_count;
  logic [15:0] utf16_units;

  modport source (output valid, output valid_flag, output valid_bytes,
                  output char_count, output utf16_units, input ready);
  modport sink (input valid, input valid_flag, input valid_bytes,
                input char_count, input utf16_units, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/u8vc_in_stage.sv =====
// Input register of the UTF-8 validator: holds one byte item for the step.
// Depends on u8vc_pkg and u8vc_byte_if.
`default_nettype none

module u8vc_in_stage
  import u8vc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  u8vc_byte_if.sink     bytes,
  input  wire logic     space,
  output byte_item_t    item,
  output logic          go
);

  logic held;

  // Step the held item whenever the result side has room
  assign go          = held && space;
  assign bytes.ready = !held || space;

  // Track occupancy of the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (bytes.ready) begin
      held <= bytes.valid;
    end
  end

  // Load the payload on accept
  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      item.data_byte <= bytes.data_byte;
      item.last_byte <= bytes.last_byte;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/u8vc_step.sv =====
// Per-byte decode step: sequence state, counters and result generation.
// Depends on u8vc_pkg.
`default_nettype none

module u8vc_step
  import u8vc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire byte_item_t item,
  input  wire logic   go,
  output logic        emit,
  output result_t     res,
  output step_status_t status
);

  logic [15:0] byte_position, byte_position_next;
  logic [15:0] chars_seen, chars_seen_next;
  logic [15:0] long_chars_seen, long_chars_seen_next;
  logic [15:0] sequence_start, sequence_start_next;
  logic [1:0]  bytes_pending, bytes_pending_next;
  logic [1:0]  sequence_length, sequence_length_next;
  logic [20:0] partial_codepoint, partial_codepoint_next;
  logic        discarding, discarding_next;

  logic [7:0]  b;
  logic [20:0] cp_shifted;
  logic        cp_bad;
  logic        res_ok;
  logic [15:0] res_bytes;
  logic [15:0] res_chars;
  logic [15:0] res_longs;
  logic [16:0] units_sum;

  assign b          = item.data_byte;
  assign cp_shifted = {partial_codepoint[14:0], b[5:0]};

  // Range check of a completed code point by its sequence length
  always_comb begin
    case (sequence_length)
      CONT_ONE: cp_bad = cp_shifted < MIN_2BYTE;
      CONT_TWO: cp_bad = (cp_shifted < MIN_3BYTE) ||
                         ((cp_shifted >= SURR_LOW) && (cp_shifted <= SURR_HIGH));
      default:  cp_bad = (cp_shifted < MIN_4BYTE) || (cp_shifted > MAX_CODEPT);
    endcase
  end

  // Next state and result for the stepped byte
  always_comb begin
    byte_position_next     = byte_position;
    chars_seen_next        = chars_seen;
    long_chars_seen_next   = long_chars_seen;
    sequence_start_next    = sequence_start;
    bytes_pending_next     = bytes_pending;
    sequence_length_next   = sequence_length;
    partial_codepoint_next = partial_codepoint;
    discarding_next        = discarding;
    emit                   = 1'b0;
    res_ok                 = 1'b0;
    res_bytes              = byte_position;

    if (go && !discarding) begin
      if (bytes_pending == 2'd0) begin
        if (b == 8'd0) begin
          emit   = 1'b1;
          res_ok = 1'b1;
        end else if (b < ASCII_TOP) begin
          chars_seen_next    = sat_inc(chars_seen);
          byte_position_next = sat_inc(byte_position);
          emit               = item.last_byte;
          res_ok             = 1'b1;
          res_bytes          = byte_position_next;
        end else if ((b & LEAD2_MASK) == LEAD2_CODE ||
                     (b & LEAD3_MASK) == LEAD3_CODE ||
                     (b & LEAD4_MASK) == LEAD4_CODE) begin
          // Open a multi-byte sequence
          if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            bytes_pending_next     = CONT_ONE;
            partial_codepoint_next = {16'd0, b[4:0]};
          end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            bytes_pending_next     = CONT_TWO;
            partial_codepoint_next = {17'd0, b[3:0]};
          end else begin
            bytes_pending_next     = CONT_THREE;
            partial_codepoint_next = {18'd0, b[2:0]};
          end
          sequence_length_next = bytes_pending_next;
          sequence_start_next  = byte_position;
          byte_position_next   = sat_inc(byte_position);
          emit                 = item.last_byte;
        end else begin
          // Stray continuation or invalid lead
          emit = 1'b1;
        end
      end else if ((b & CONT_MASK) != CONT_CODE) begin
        emit      = 1'b1;
        res_bytes = sequence_start;
      end else begin
        partial_codepoint_next = cp_shifted;
        bytes_pending_next     = bytes_pending - 2'd1;
        byte_position_next     = sat_inc(byte_position);
        res_bytes              = sequence_start;
        if (bytes_pending == CONT_ONE) begin
          if (cp_bad) begin
            emit = 1'b1;
          end else begin
            chars_seen_next = sat_inc(chars_seen);
            if (sequence_length == CONT_THREE) begin
              long_chars_seen_next = sat_inc(long_chars_seen);
            end
            partial_codepoint_next = 21'd0;
            sequence_length_next   = 2'd0;
            emit                   = item.last_byte;
            res_ok                 = 1'b1;
            res_bytes              = byte_position_next;
          end
        end else begin
          // Sequence still open; cut off if this is the buffer end
          emit = item.last_byte;
        end
      end
      if (emit) begin
        discarding_next = 1'b1;
      end
    end

    // Take the result counts before any end-of-buffer clear
    res_chars = chars_seen_next;
    res_longs = long_chars_seen_next;

    // Clear everything at the end of a buffer
    if (go && item.last_byte) begin
      byte_position_next     = 16'd0;
      chars_seen_next        = 16'd0;
      long_chars_seen_next   = 16'd0;
      sequence_start_next    = 16'd0;
      bytes_pending_next     = 2'd0;
      sequence_length_next   = 2'd0;
      partial_codepoint_next = 21'd0;
      discarding_next        = 1'b0;
    end
  end

  // Result fields come from the counters as updated by this byte
  always_comb begin
    units_sum       = {1'b0, res_chars} + {1'b0, res_longs};
    res.valid_flag  = res_ok;
    res.valid_bytes = res_bytes;
    res.char_count  = res_chars;
    res.utf16_units = units_sum[16] ? 16'hFFFF : units_sum[15:0];
  end

  // Hold sequence state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= 16'd0;
      chars_seen        <= 16'd0;
      long_chars_seen   <= 16'd0;
      sequence_start    <= 16'd0;
      bytes_pending     <= 2'd0;
      sequence_length   <= 2'd0;
      partial_codepoint <= 21'd0;
      discarding        <= 1'b0;
    end else begin
      byte_position     <= byte_position_next;
      chars_seen        <= chars_seen_next;
      long_chars_seen   <= long_chars_seen_next;
      sequence_start    <= sequence_start_next;
      bytes_pending     <= bytes_pending_next;
      sequence_length   <= sequence_length_next;
      partial_codepoint <= partial_codepoint_next;
      discarding        <= discarding_next;
    end
  end

  assign status.discarding      = discarding;
  assign status.bytes_pending   = bytes_pending;
  assign status.sequence_length = sequence_length;

endmodule

`default_nettype wire

// ===== hw/rtl/u8vc_out_stage.sv =====
// Result register of the UTF-8 validator, drives the result channel.
// Depends on u8vc_pkg and u8vc_result_if.
`default_nettype none

module u8vc_out_stage
  import u8vc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load,
  input  wire result_t   res,
  output logic           space,
  u8vc_result_if.source  results
);

  logic    full;
  result_t held;

  // Room for a new result once the current one is taken or absent
  assign space = !full || results.ready;

  // Track occupancy of the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (results.ready) begin
      full <= 1'b0;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign results.valid       = full;
  assign results.valid_flag  = held.valid_flag;
  assign results.valid_bytes = held.valid_bytes;
  assign results.char_count  = held.char_count;
  assign results.utf16_units = held.utf16_units;

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_validate_count.sv =====
// UTF-8 validator and counter: one byte item per cycle, one result per buffer.
// A result is computed by the decode step from the byte in the input register and held in the result register.
// Throughput: one byte per cycle through the combinational decode step between
// the input register and the result register; stalls only on result backpressure.
// Reset (rst, synchronous) clears counters and sequence state and empties both registers.
// Depends on u8vc_pkg, the channel interfaces, the stages and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module utf8_validate_count
  import u8vc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  u8vc_byte_if.sink      bytes,
  u8vc_result_if.source  results
);

  byte_item_t   item;
  logic         go;
  logic         space;
  logic         emit;
  result_t      res;
  step_status_t status;

  u8vc_in_stage u_in (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes),
    .space (space),
    .item  (item),
    .go    (go)
  );

  u8vc_step u_step (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .go     (go),
    .emit   (emit),
    .res    (res),
    .status (status)
  );

  u8vc_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (emit),
    .res     (res),
    .space   (space),
    .results (results)
  );

  // An early result puts the step into drop mode
  `U8VC_ASSERT_NEXT(a_drop_after_early, clk, rst, emit && !item.last_byte, status.discarding)
  // A buffer end leaves the step clean for the next buffer
  `U8VC_ASSERT_NEXT(a_clean_after_last, clk, rst, go && item.last_byte, !status.discarding && status.bytes_pending == 2'd0)
  // Pending continuations never exceed the opened sequence
  `U8VC_ASSERT_ALWAYS(a_pending_bound, clk, rst, status.bytes_pending <= status.sequence_length)
  // Results come only from a stepped, non-dropped byte
  `U8VC_ASSERT_ALWAYS(a_emit_source, clk, rst, !emit || (go && !status.discarding))

endmodule

`default_nettype wire

// ===== test/utf8_validate_count_test.sv =====
// Testbench of utf8_validate_count: drives byte buffers, checks every result item.
// Depends on u8vc_pkg, u8vc_byte_if, u8vc_result_if and the utf8_validate_count RTL.
`timescale 1ns / 1ps

module utf8_validate_count_test;
  import u8vc_pkg::*;

  // Kinds of damage that a random buffer may carry
  typedef enum int {
    FLAW_NONE,
    FLAW_STRAY,
    FLAW_BAD_LEAD,
    FLAW_OVERLONG,
    FLAW_SURROGATE,
    FLAW_RANGE,
    FLAW_BAD_CONT,
    FLAW_ZERO_IN_SEQ,
    FLAW_ZERO_END,
    FLAW_CUT,
    FLAW_NOISE
  } flaw_e;

  // Tracks the decoder state of the stream and the results it must produce
  class utf8_tally_board;
    logic [15:0] pos, chars, quads, seq_start;
    logic [1:0]  pending, seq_len;
    logic [20:0] partial;
    bit          dropping;
    result_t     expected_q[$];
    int unsigned mismatches, checked;

    function new();
      clear();
      mismatches = 0;
      checked    = 0;
    endfunction

    function void clear();
      pos       = '0;
      chars     = '0;
      quads     = '0;
      seq_start = '0;
      pending   = '0;
      seq_len   = '0;
      partial   = '0;
      dropping  = 1'b0;
    endfunction

    function logic [15:0] bump(logic [15:0] x);
      return (x < COUNT_CAP) ? x + 16'd1 : COUNT_CAP;
    endfunction

    // Queue the result of the buffer; restart on the last byte, else drop the rest
    function void close_buffer(bit ok, logic [15:0] offset, bit last_in);
      result_t     r;
      logic [16:0] units;
      units         = {1'b0, chars} + {1'b0, quads};
      r.valid_flag  = ok;
      r.valid_bytes = offset;
      r.char_count  = chars;
      r.utf16_units = units[16] ? 16'hFFFF : units[15:0];
      expected_q.push_back(r);
      if (last_in) clear();
      else dropping = 1'b1;
    endfunction

    // Advance the decoder by one accepted byte item
    function void take_byte(logic [7:0] b, logic last_in);
      logic [1:0]  n;
      logic [20:0] cp;
      bit          bad;
      if (dropping) begin
        if (last_in) clear();
        return;
      end
      if (pending == 2'd0) begin
        if (b == 8'h00) begin
          close_buffer(1'b1, pos, last_in);
          return;
        end
        if (b < ASCII_TOP) begin
          chars = bump(chars);
          pos   = bump(pos);
          if (last_in) close_buffer(1'b1, pos, 1'b1);
          return;
        end
        if ((b & LEAD2_MASK) == LEAD2_CODE) begin
          n       = CONT_ONE;
          partial = {16'd0, b[4:0]};
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
          n       = CONT_TWO;
          partial = {17'd0, b[3:0]};
        end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
          n       = CONT_THREE;
          partial = {18'd0, b[2:0]};
        end else begin
          close_buffer(1'b0, pos, last_in);
          return;
        end
        seq_start = pos;
        pending   = n;
        seq_len   = n;
        pos       = bump(pos);
        if (last_in) close_buffer(1'b0, seq_start, 1'b1);
        return;
      end
      // Continuation byte of an open sequence
      if ((b & CONT_MASK) != CONT_CODE) begin
        close_buffer(1'b0, seq_start, last_in);
        return;
      end
      partial = {partial[14:0], b[5:0]};
      pending = pending - 2'd1;
      pos     = bump(pos);
      if (pending == 2'd0) begin
        cp = partial;
        case (seq_len)
          CONT_ONE: bad = cp < MIN_2BYTE;
          CONT_TWO: bad = cp < MIN_3BYTE || (cp >= SURR_LOW && cp <= SURR_HIGH);
          default:  bad = cp < MIN_4BYTE || cp > MAX_CODEPT;
        endcase
        if (bad) begin
          close_buffer(1'b0, seq_start, last_in);
          return;
        end
        chars = bump(chars);
        if (seq_len == CONT_THREE) quads = bump(quads);
        partial = '0;
        seq_len = '0;
        if (last_in) close_buffer(1'b1, pos, 1'b1);
        return;
      end
      if (last_in) close_buffer(1'b0, seq_start, 1'b1);
    endfunction

    // Compare one accepted result item with the oldest expected one
    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: flag=%0d bytes=%0d chars=%0d units=%0d",
                   got.valid_flag, got.valid_bytes, got.char_count, got.utf16_units);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.valid_flag !== want.valid_flag || got.valid_bytes !== want.valid_bytes ||
          got.char_count !== want.char_count || got.utf16_units !== want.utf16_units) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected flag=%0d bytes=%0d chars=%0d units=%0d, got %0d %0d %0d %0d",
                   checked, want.valid_flag, want.valid_bytes, want.char_count,
                   want.utf16_units, got.valid_flag, got.valid_bytes, got.char_count,
                   got.utf16_units);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  u8vc_byte_if   byte_ch ();
  u8vc_result_if result_ch ();

  utf8_validate_count u_top (
    .clk     (clk),
    .rst     (rst),
    .bytes   (byte_ch),
    .results (result_ch)
  );

  utf8_tally_board board;
  int unsigned     send_idle, recv_idle;
  int unsigned     bytes_sent, buffers_sent;
  logic [7:0]      buf_q[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stall the result side at random
  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  // Note accepted byte items and check accepted result items
  always @(posedge clk) begin
    if (!rst) begin
      if (byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1)
        board.take_byte(byte_ch.data_byte, byte_ch.last_byte);
      if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        board.check_result('{result_ch.valid_flag, result_ch.valid_bytes,
                             result_ch.char_count, result_ch.utf16_units});
    end
  end

  // Offer one byte item, idling first at random; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last_in);
    while ($urandom_range(99) < send_idle) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= last_in;
    do @(posedge clk); while (byte_ch.ready !== 1'b1);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_buffer(input logic [7:0] q[$]);
    for (int i = 0; i < q.size(); i++)
      send_byte(q[i], i == q.size() - 1);
    buffers_sent++;
  endtask

  // Encode a value in a given number of bytes, overlong or out of range if asked
  function automatic void add_form(ref logic [7:0] q[$], input logic [20:0] cp,
                                   input int nb);
    case (nb)
      1: q.push_back({1'b0, cp[6:0]});
      2: begin
        q.push_back({3'b110, cp[10:6]});
        q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        q.push_back({4'b1110, cp[15:12]});
        q.push_back({2'b10, cp[11:6]});
        q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        q.push_back({5'b11110, cp[20:18]});
        q.push_back({2'b10, cp[17:12]});
        q.push_back({2'b10, cp[11:6]});
        q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic int form_len(logic [20:0] cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  // Pick a legal nonzero code point, now and then one at a class boundary
  function automatic logic [20:0] pick_codepoint();
    int unsigned r;
    logic [20:0] cp;
    r = $urandom_range(99);
    if (r < 8) begin
      case ($urandom_range(9))
        0: cp = 21'h1;
        1: cp = 21'h7F;
        2: cp = 21'h80;
        3: cp = 21'h7FF;
        4: cp = 21'h800;
        5: cp = 21'hD7FF;
        6: cp = 21'hE000;
        7: cp = 21'hFFFF;
        8: cp = 21'h10000;
        default: cp = 21'h10FFFF;
      endcase
    end else if (r < 40) begin
      cp = 21'($urandom_range(21'h7F, 21'h1));
    end else if (r < 60) begin
      cp = 21'($urandom_range(21'h7FF, 21'h80));
    end else if (r < 80) begin
      cp = 21'($urandom_range(21'hFFFF, 21'h800));
      // move surrogates up into the legal top of the plane
      if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h2000;
    end else begin
      cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
    end
    return cp;
  endfunction

  function automatic logic [20:0] pick_multibyte();
    logic [20:0] cp;
    do cp = pick_codepoint(); while (form_len(cp) < 2);
    return cp;
  endfunction

  // Append one damaged piece of text
  function automatic void add_flaw(ref logic [7:0] q[$], input flaw_e f);
    logic [7:0]  tmp[$];
    logic [7:0]  b;
    int          nb, k;
    logic [20:0] cp;
    case (f)
      FLAW_STRAY:    q.push_back(8'($urandom_range(8'hBF, 8'h80)));
      FLAW_BAD_LEAD: q.push_back(8'($urandom_range(8'hFF, 8'hF8)));
      FLAW_OVERLONG: begin
        nb = $urandom_range(4, 2);
        if (nb == 2) cp = 21'($urandom_range(21'h7F, 0));
        else if (nb == 3) cp = 21'($urandom_range(21'h7FF, 0));
        else cp = 21'($urandom_range(21'hFFFF, 0));
        add_form(q, cp, nb);
      end
      FLAW_SURROGATE: add_form(q, 21'($urandom_range(21'hDFFF, 21'hD800)), 3);
      FLAW_RANGE:     add_form(q, 21'($urandom_range(21'h1FFFFF, 21'h110000)), 4);
      FLAW_BAD_CONT, FLAW_ZERO_IN_SEQ: begin
        cp = pick_multibyte();
        add_form(tmp, cp, form_len(cp));
        k = $urandom_range(tmp.size() - 1, 1);
        if (f == FLAW_ZERO_IN_SEQ) begin
          b = 8'h00;
        end else begin
          do b = 8'($urandom_range(255)); while ((b & CONT_MASK) == CONT_CODE);
        end
        for (int i = 0; i < k; i++) q.push_back(tmp[i]);
        q.push_back(b);
      end
      FLAW_ZERO_END: q.push_back(8'h00);
      FLAW_CUT: begin
        cp = pick_multibyte();
        add_form(tmp, cp, form_len(cp));
        k = $urandom_range(tmp.size() - 1, 1);
        for (int i = 0; i < k; i++) q.push_back(tmp[i]);
      end
      default: ;
    endcase
  endfunction

  // Build a random buffer: mostly legal text, some damaged, some raw noise
  function automatic void build_buffer(ref logic [7:0] q[$]);
    int          nchars, k;
    flaw_e       f;
    logic [20:0] cp;
    q.delete();
    nchars = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(8, 1);
    f = ($urandom_range(99) < 55) ? FLAW_NONE : flaw_e'($urandom_range(FLAW_NOISE, FLAW_STRAY));
    if (f == FLAW_NOISE) begin
      for (int i = $urandom_range(12, 1); i > 0; i--) q.push_back(8'($urandom_range(255)));
      return;
    end
    k = $urandom_range(nchars, 0);
    for (int i = 0; i < nchars; i++) begin
      if (i == k && f != FLAW_NONE && f != FLAW_CUT) add_flaw(q, f);
      cp = pick_codepoint();
      add_form(q, cp, form_len(cp));
    end
    if (f == FLAW_CUT || (k == nchars && f != FLAW_NONE)) add_flaw(q, f);
  endfunction

  task automatic run_random(input int unsigned upto);
    while (bytes_sent < upto) begin
      build_buffer(buf_q);
      send_buffer(buf_q);
    end
  endtask

  initial begin
    board             = new();
    send_idle         = 29;
    recv_idle         = 78;
    bytes_sent        = 0;
    buffers_sent      = 0;
    rst               = 1'b1;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = 8'h00;
    byte_ch.last_byte = 1'b0;
    result_ch.ready   = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed buffers: field extremes and each fault kind
    buf_q = '{8'h00};                      send_buffer(buf_q);
    buf_q = '{8'h7F};                      send_buffer(buf_q);
    buf_q = '{8'hFF};                      send_buffer(buf_q);
    buf_q = '{8'hE2};                      send_buffer(buf_q);
    buf_q = '{8'h80, 8'h41};               send_buffer(buf_q);
    buf_q = '{8'hC1, 8'hBF};               send_buffer(buf_q);
    buf_q = '{8'hED, 8'hA0, 8'h80};        send_buffer(buf_q);
    buf_q = '{8'hF4, 8'h90, 8'h80, 8'h80}; send_buffer(buf_q);
    buf_q = '{8'hE2, 8'h82};               send_buffer(buf_q);
    buf_q = '{8'hC3, 8'h00, 8'h41};        send_buffer(buf_q);
    buf_q = '{8'h41, 8'h00, 8'h42};        send_buffer(buf_q);
    buf_q = '{8'hF0, 8'h9F, 8'h98, 8'h80}; send_buffer(buf_q);

    // Random buffers under three idle patterns
    run_random(520);
    send_idle = 78;
    recv_idle = 29;
    run_random(1040);
    send_idle = 0;
    recv_idle = 0;
    run_random(1550);

    // Drain outstanding results, then allow the pipeline latency
    byte_ch.valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("sent %0d byte items in %0d buffers; %0d results checked, %0d mismatches",
             bytes_sent, buffers_sent, board.checked, board.mismatches);
    if (board.mismatches == 0 && board.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", board.expected_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
